@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

@@ rtl/core/lrw_pkg.sv @@
`default_nettype none

package lrw_pkg;

    // Coordinate bits that the stepper uses; ports keep the full point width.
    localparam int COORD_BITS = 6;
    localparam int POINT_W    = 6;
    localparam int DIM_W      = 7;
    localparam int INDEX_W    = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // The balance needs two bits above twice the largest delta plus a sign.
    localparam int BAL_W      = COORD_BITS + 3;
    localparam int DIV_CNT_W  = $clog2(COORD_BITS);

    // Command queue between the front and the stepper.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(64);
    localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LAYER_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LAYER_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_ENABLE  = CFG_IDX_W'(2);

    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_MOD,
        FRONT_PUSH
    } front_state_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_RUN
    } back_state_t;

    // One classified line command, ready for the stepper.
    typedef struct packed {
        logic [COORD_BITS-1:0]   start_col;
        logic [COORD_BITS-1:0]   start_row;
        logic [COORD_BITS-1:0]   wrap_col;
        logic [COORD_BITS-1:0]   wrap_row;
        logic                    major_is_col;
        logic                    col_neg;
        logic                    row_neg;
        logic signed [BAL_W-1:0] bal_init;
        logic signed [BAL_W-1:0] bal_dec;
        logic signed [BAL_W-1:0] bal_inc;
        logic [COORD_BITS-1:0]   count;
    } lrw_cmd_t;

    // Maps a written layer dimension into the range 1 to 64.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_MIN;
        end else if (v > DIM_MAX) begin
            r = DIM_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/lrw_front.sv @@
`default_nettype none
`include "assert_macros.svh"

module lrw_front
    import lrw_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [POINT_W-1:0] s_start_col,
    input  wire logic [POINT_W-1:0] s_start_row,
    input  wire logic [POINT_W-1:0] s_end_col,
    input  wire logic [POINT_W-1:0] s_end_row,
    input  wire logic [DIM_W-1:0]   layer_width,
    input  wire logic [DIM_W-1:0]   layer_height,
    output logic                    push_valid,
    input  wire logic               push_ready,
    output lrw_cmd_t                push_cmd
);

    front_state_t state_reg, state_next;

    logic [COORD_BITS-1:0] x0_reg, x0_next;
    logic [COORD_BITS-1:0] y0_reg, y0_next;
    logic [COORD_BITS-1:0] x1_reg, x1_next;
    logic [COORD_BITS-1:0] y1_reg, y1_next;
    logic [DIM_W-1:0]      rem_col_reg, rem_col_next;
    logic [DIM_W-1:0]      rem_row_reg, rem_row_next;
    logic [DIV_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;

    logic                  accept;
    logic                  col_neg;
    logic                  row_neg;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic                  major_is_col;
    logic [COORD_BITS-1:0] d_major;
    logic [COORD_BITS-1:0] d_minor;
    logic signed [BAL_W-1:0] twice_minor;
    logic signed [BAL_W-1:0] twice_major;
    logic signed [BAL_W-1:0] major_ext;
    logic                  rem_ok;

    // One restoring step of the remainder: shift in a dividend bit, subtract if it fits.
    function automatic logic [DIM_W-1:0] mod_step(
        input logic [DIM_W-1:0] rem,
        input logic             din,
        input logic [DIM_W-1:0] divisor
    );
        logic [DIM_W-1:0] trial;
        trial = {rem[DIM_W-2:0], din};
        if (trial >= divisor) begin
            trial = trial - divisor;
        end
        return trial;
    endfunction

    assign accept = s_valid && s_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FRONT_IDLE: begin
                if (s_valid) begin
                    state_next = FRONT_MOD;
                end
            end
            FRONT_MOD: begin
                if (bit_cnt_reg == '0) begin
                    state_next = FRONT_PUSH;
                end
            end
            FRONT_PUSH: begin
                if (push_ready) begin
                    state_next = FRONT_IDLE;
                end
            end
            default: begin
                state_next = FRONT_IDLE;
            end
        endcase
    end

    // Handshake outputs.
    always_comb begin
        s_ready    = 1'b0;
        push_valid = 1'b0;
        unique case (state_reg)
            FRONT_IDLE: s_ready    = 1'b1;
            FRONT_MOD:  s_ready    = 1'b0;
            FRONT_PUSH: push_valid = 1'b1;
            default:    s_ready    = 1'b0;
        endcase
    end

    // Capture the endpoints and reduce the start point modulo the layer, one bit a cycle.
    always_comb begin
        x0_next      = x0_reg;
        y0_next      = y0_reg;
        x1_next      = x1_reg;
        y1_next      = y1_reg;
        rem_col_next = rem_col_reg;
        rem_row_next = rem_row_reg;
        bit_cnt_next = bit_cnt_reg;
        if (accept) begin
            x0_next      = s_start_col[COORD_BITS-1:0];
            y0_next      = s_start_row[COORD_BITS-1:0];
            x1_next      = s_end_col[COORD_BITS-1:0];
            y1_next      = s_end_row[COORD_BITS-1:0];
            rem_col_next = '0;
            rem_row_next = '0;
            bit_cnt_next = DIV_CNT_W'(COORD_BITS - 1);
        end else if (state_reg == FRONT_MOD) begin
            rem_col_next = mod_step(rem_col_reg, x0_reg[bit_cnt_reg], layer_width);
            rem_row_next = mod_step(rem_row_reg, y0_reg[bit_cnt_reg], layer_height);
            bit_cnt_next = bit_cnt_reg - 1'b1;
        end
    end

    // Classify the line: deltas, directions, major axis and balance terms.
    always_comb begin
        col_neg      = x1_reg < x0_reg;
        row_neg      = y1_reg < y0_reg;
        dx           = col_neg ? (x0_reg - x1_reg) : (x1_reg - x0_reg);
        dy           = row_neg ? (y0_reg - y1_reg) : (y1_reg - y0_reg);
        major_is_col = dx >= dy;
        d_major      = major_is_col ? dx : dy;
        d_minor      = major_is_col ? dy : dx;
        twice_minor  = BAL_W'({d_minor, 1'b0});
        twice_major  = BAL_W'({d_major, 1'b0});
        major_ext    = BAL_W'(d_major);

        push_cmd.start_col    = x0_reg;
        push_cmd.start_row    = y0_reg;
        push_cmd.wrap_col     = rem_col_reg[COORD_BITS-1:0];
        push_cmd.wrap_row     = rem_row_reg[COORD_BITS-1:0];
        push_cmd.major_is_col = major_is_col;
        push_cmd.col_neg      = col_neg;
        push_cmd.row_neg      = row_neg;
        push_cmd.bal_init     = twice_minor - major_ext;
        push_cmd.bal_dec      = twice_minor - twice_major;
        push_cmd.bal_inc      = twice_minor;
        push_cmd.count        = d_major;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FRONT_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        x0_reg      <= x0_next;
        y0_reg      <= y0_next;
        x1_reg      <= x1_next;
        y1_reg      <= y1_next;
        rem_col_reg <= rem_col_next;
        rem_row_reg <= rem_row_next;
        bit_cnt_reg <= bit_cnt_next;
    end

    // The partial remainders must stay below their divisors.
    assign rem_ok = (rem_col_reg < layer_width) && (rem_row_reg < layer_height);

    `ASSERT_CLK(a_front_rem_bound, aclk, aresetn, (state_reg != FRONT_IDLE) |-> rem_ok, "start remainder out of range")

endmodule

`default_nettype wire

@@ rtl/core/lrw_cmd_q.sv @@
`default_nettype none
`include "assert_macros.svh"

module lrw_cmd_q
    import lrw_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push_valid,
    output logic          push_ready,
    input  wire lrw_cmd_t push_cmd,
    output logic          pop_valid,
    input  wire logic     pop_ready,
    output lrw_cmd_t      pop_cmd
);

    lrw_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    logic              pop;
    logic              ptr_edge;
    logic              ptr_match;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Command storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // An empty or full queue has its pointers together.
    assign ptr_edge  = (count_reg == '0) || (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign ptr_match = wr_ptr_reg == rd_ptr_reg;

    `ASSERT_CLK(a_q_ptr_track, aclk, aresetn, ptr_edge |-> ptr_match, "queue pointers disagree with fill count")
    `ASSERT_NEVER(a_q_overfill, aclk, aresetn, count_reg > QCNT_W'(QUEUE_DEPTH), "queue fill count beyond depth")

endmodule

`default_nettype wire

@@ rtl/core/lrw_back.sv @@
`default_nettype none
`include "assert_macros.svh"

module lrw_back
    import lrw_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [DIM_W-1:0] layer_width,
    input  wire logic [DIM_W-1:0] layer_height,
    input  wire logic             wrap_enable,
    input  wire logic             pop_valid,
    output logic                  pop_ready,
    input  wire lrw_cmd_t         pop_cmd,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [POINT_W-1:0]    m_point_col,
    output logic [POINT_W-1:0]    m_point_row,
    output logic [INDEX_W-1:0]    m_pixel_index,
    output logic                  m_on_layer,
    output logic                  m_last_point
);

    localparam int PROD_W = DIM_W + COORD_BITS;

    back_state_t state_reg, state_next;

    logic [COORD_BITS-1:0]   col_reg, col_next;
    logic [COORD_BITS-1:0]   row_reg, row_next;
    logic [COORD_BITS-1:0]   wcol_reg, wcol_next;
    logic [COORD_BITS-1:0]   wrow_reg, wrow_next;
    logic signed [BAL_W-1:0] bal_reg, bal_next;
    logic signed [BAL_W-1:0] dec_reg, dec_next;
    logic signed [BAL_W-1:0] inc_reg, inc_next;
    logic [COORD_BITS-1:0]   cnt_reg, cnt_next;
    logic                    major_is_col_reg, major_is_col_next;
    logic                    col_neg_reg, col_neg_next;
    logic                    row_neg_reg, row_neg_next;

    logic                    m_valid_reg, m_valid_next;
    logic [POINT_W-1:0]      m_point_col_reg;
    logic [POINT_W-1:0]      m_point_row_reg;
    logic [INDEX_W-1:0]      m_pixel_index_reg;
    logic                    m_on_layer_reg;
    logic                    m_last_point_reg;

    logic                    emit;
    logic                    line_done;
    logic                    load;
    logic                    bal_nonneg;
    logic                    step_col;
    logic                    step_row;
    logic                    in_layer;
    logic                    on_layer;
    logic [PROD_W-1:0]       prod;
    logic [PROD_W-1:0]       index_sum;
    logic [INDEX_W-1:0]      pixel_index;
    logic                    wrap_ok;

    // Wrapped coordinate after a step up or down, kept below the divisor.
    function automatic logic [COORD_BITS-1:0] wrap_up(
        input logic [COORD_BITS-1:0] v,
        input logic [DIM_W-1:0]      divisor
    );
        logic [COORD_BITS-1:0] r;
        if (DIM_W'(v) == divisor - 1'b1) begin
            r = '0;
        end else begin
            r = v + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [COORD_BITS-1:0] wrap_down(
        input logic [COORD_BITS-1:0] v,
        input logic [DIM_W-1:0]      divisor
    );
        logic [COORD_BITS-1:0] r;
        if (v == '0) begin
            r = COORD_BITS'(divisor - 1'b1);
        end else begin
            r = v - 1'b1;
        end
        return r;
    endfunction

    // Stepper control.
    always_comb begin
        emit      = (state_reg == BACK_RUN) && (!m_valid_reg || m_ready);
        line_done = emit && (cnt_reg == '0);
        pop_ready = (state_reg == BACK_IDLE) || line_done;
        load      = pop_valid && pop_ready;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BACK_IDLE: begin
                if (pop_valid) begin
                    state_next = BACK_RUN;
                end
            end
            BACK_RUN: begin
                if (line_done && !pop_valid) begin
                    state_next = BACK_IDLE;
                end
            end
            default: begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    // Bresenham step: the major axis moves every point, the minor one on a nonnegative balance.
    always_comb begin
        bal_nonneg = !bal_reg[BAL_W-1];
        step_col   = major_is_col_reg || bal_nonneg;
        step_row   = !major_is_col_reg || bal_nonneg;

        col_next          = col_reg;
        row_next          = row_reg;
        wcol_next         = wcol_reg;
        wrow_next         = wrow_reg;
        bal_next          = bal_reg;
        dec_next          = dec_reg;
        inc_next          = inc_reg;
        cnt_next          = cnt_reg;
        major_is_col_next = major_is_col_reg;
        col_neg_next      = col_neg_reg;
        row_neg_next      = row_neg_reg;

        if (load) begin
            col_next          = pop_cmd.start_col;
            row_next          = pop_cmd.start_row;
            wcol_next         = pop_cmd.wrap_col;
            wrow_next         = pop_cmd.wrap_row;
            bal_next          = pop_cmd.bal_init;
            dec_next          = pop_cmd.bal_dec;
            inc_next          = pop_cmd.bal_inc;
            cnt_next          = pop_cmd.count;
            major_is_col_next = pop_cmd.major_is_col;
            col_neg_next      = pop_cmd.col_neg;
            row_neg_next      = pop_cmd.row_neg;
        end else if (emit) begin
            cnt_next = cnt_reg - 1'b1;
            bal_next = bal_reg + (bal_nonneg ? dec_reg : inc_reg);
            if (step_col) begin
                col_next  = col_neg_reg ? col_reg - 1'b1 : col_reg + 1'b1;
                wcol_next = col_neg_reg ? wrap_down(wcol_reg, layer_width)
                                        : wrap_up(wcol_reg, layer_width);
            end
            if (step_row) begin
                row_next  = row_neg_reg ? row_reg - 1'b1 : row_reg + 1'b1;
                wrow_next = row_neg_reg ? wrap_down(wrow_reg, layer_height)
                                        : wrap_up(wrow_reg, layer_height);
            end
        end
    end

    // Layer mapping of the current point; the wrapped pair equals the point when inside.
    always_comb begin
        in_layer    = (DIM_W'(col_reg) < layer_width) && (DIM_W'(row_reg) < layer_height);
        on_layer    = in_layer || wrap_enable;
        prod        = PROD_W'(layer_width) * PROD_W'(wrow_reg);
        index_sum   = prod + PROD_W'(wcol_reg);
        pixel_index = on_layer ? index_sum[INDEX_W-1:0] : '0;
    end

    // Output word register.
    always_comb begin
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BACK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg          <= col_next;
        row_reg          <= row_next;
        wcol_reg         <= wcol_next;
        wrow_reg         <= wrow_next;
        bal_reg          <= bal_next;
        dec_reg          <= dec_next;
        inc_reg          <= inc_next;
        cnt_reg          <= cnt_next;
        major_is_col_reg <= major_is_col_next;
        col_neg_reg      <= col_neg_next;
        row_neg_reg      <= row_neg_next;
        if (emit) begin
            m_point_col_reg   <= POINT_W'(col_reg);
            m_point_row_reg   <= POINT_W'(row_reg);
            m_pixel_index_reg <= pixel_index;
            m_on_layer_reg    <= on_layer;
            m_last_point_reg  <= cnt_reg == '0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_point_col   = m_point_col_reg;
    assign m_point_row   = m_point_row_reg;
    assign m_pixel_index = m_pixel_index_reg;
    assign m_on_layer    = m_on_layer_reg;
    assign m_last_point  = m_last_point_reg;

    // The tracked wrapped coordinates stay inside the layer while a line runs.
    assign wrap_ok = (DIM_W'(wcol_reg) < layer_width) && (DIM_W'(wrow_reg) < layer_height);

    `ASSERT_CLK(a_back_wrap_bound, aclk, aresetn, (state_reg == BACK_RUN) |-> wrap_ok,
                "wrapped coordinate left the layer")
    `ASSERT_CLK(a_back_done_idle, aclk, aresetn,
                (line_done && !pop_valid) |=> (state_reg == BACK_IDLE),
                "stepper kept running after the last point")

endmodule

`default_nettype wire

@@ rtl/core/line_rasterizer_with_wrap.sv @@
`default_nettype none

// Bresenham line rasterizer with layer wrapping. Each input word is one line
// command (start and end point); the block returns one output word per point,
// from start to end inclusive, max(|dx|,|dy|)+1 words, the final one marked by
// m_last_point. Each point carries its linear index col + layer_width*row;
// points outside the layer are wrapped by modulo or, with wrap_enable low,
// flagged off layer with index 0. Configuration writes through the cfg port
// must happen while the block is idle. The front classifies each command and
// reduces its start point modulo the layer, one remainder bit per cycle; the
// back stepper then produces one point per cycle while m_ready is high. A
// two-entry command queue lets the front prepare the next lines while the
// stepper runs.
module line_rasterizer_with_wrap
    import lrw_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [POINT_W-1:0]    s_start_col,
    input  wire logic [POINT_W-1:0]    s_start_row,
    input  wire logic [POINT_W-1:0]    s_end_col,
    input  wire logic [POINT_W-1:0]    s_end_row,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [POINT_W-1:0]         m_point_col,
    output logic [POINT_W-1:0]         m_point_row,
    output logic [INDEX_W-1:0]         m_pixel_index,
    output logic                       m_on_layer,
    output logic                       m_last_point
);

    logic [DIM_W-1:0] layer_width_reg, layer_width_next;
    logic [DIM_W-1:0] layer_height_reg, layer_height_next;
    logic             wrap_enable_reg, wrap_enable_next;

    logic             q_push_valid;
    logic             q_push_ready;
    lrw_cmd_t         q_push_cmd;
    logic             q_pop_valid;
    logic             q_pop_ready;
    lrw_cmd_t         q_pop_cmd;

    assign cfg_ready = 1'b1;

    // Configuration registers; dimensions are stored already clamped to 1..64.
    always_comb begin
        layer_width_next  = layer_width_reg;
        layer_height_next = layer_height_reg;
        wrap_enable_next  = wrap_enable_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_LAYER_WIDTH:  layer_width_next  = clamp_dim(cfg_data);
                REG_LAYER_HEIGHT: layer_height_next = clamp_dim(cfg_data);
                REG_WRAP_ENABLE:  wrap_enable_next  = cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layer_width_reg  <= DIM_MAX;
            layer_height_reg <= DIM_MAX;
            wrap_enable_reg  <= 1'b1;
        end else begin
            layer_width_reg  <= layer_width_next;
            layer_height_reg <= layer_height_next;
            wrap_enable_reg  <= wrap_enable_next;
        end
    end

    // Front: accepts and classifies line commands.
    lrw_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_start_col  (s_start_col),
        .s_start_row  (s_start_row),
        .s_end_col    (s_end_col),
        .s_end_row    (s_end_row),
        .layer_width  (layer_width_reg),
        .layer_height (layer_height_reg),
        .push_valid   (q_push_valid),
        .push_ready   (q_push_ready),
        .push_cmd     (q_push_cmd)
    );

    // Command queue between front and stepper.
    lrw_cmd_q u_cmd_q (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_cmd   (q_push_cmd),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_cmd    (q_pop_cmd)
    );

    // Back: steps each line and drives the output words.
    lrw_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .layer_width   (layer_width_reg),
        .layer_height  (layer_height_reg),
        .wrap_enable   (wrap_enable_reg),
        .pop_valid     (q_pop_valid),
        .pop_ready     (q_pop_ready),
        .pop_cmd       (q_pop_cmd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_col   (m_point_col),
        .m_point_row   (m_point_row),
        .m_pixel_index (m_pixel_index),
        .m_on_layer    (m_on_layer),
        .m_last_point  (m_last_point)
    );

endmodule

`default_nettype wire
